// ===== hdl/bc1_bc2_bc3_block_decoder_assert.svh =====
// assertion macros shared by the block decoder checkers
// no dependencies; included by bare file name
`ifndef BC1_BC2_BC3_BLOCK_DECODER_ASSERT_SVH
`define BC1_BC2_BC3_BLOCK_DECODER_ASSERT_SVH

// property that must hold in the same cycle
`define BCDEC_ASSERT_NOW(label, clk, rstn, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);

// implication checked in the cycle after the trigger
`define BCDEC_ASSERT_NEXT(label, clk, rstn, pre, post, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (pre) |=> (post)) else $error(msg);

`endif

// ===== hdl/bcdec_pkg.sv =====
// shared types, format codes and divide helpers for the block decoder
// no dependencies
package bcdec_pkg;

    typedef enum logic [1:0] {
        FMT_DXT1_RGB  = 2'd0,
        FMT_DXT1_RGBA = 2'd1,
        FMT_DXT3      = 2'd2,
        FMT_DXT5      = 2'd3
    } fmt_t;

    localparam logic [7:0] ALPHA_OPAQUE = 8'd255;
    localparam logic [7:0] ALPHA_CLEAR  = 8'd0;
    localparam logic [3:0] TEXEL_LAST   = 4'd15;
    localparam logic [5:0] DXT5_IDX_LSB = 6'd16;

    // after the endpoint / weighted-sum stage
    typedef struct packed {
        fmt_t              fmt;
        logic              four;
        logic              punch;
        logic [2:0][7:0]   c0;
        logic [2:0][7:0]   c1;
        logic [2:0][7:0]   mid;
        logic [2:0][9:0]   s2;
        logic [2:0][9:0]   s3;
        logic [7:0]        a0;
        logic [7:0]        a1;
        logic              a_gt;
        logic [5:0][10:0]  asum;
        logic [31:0]       idx;
        logic [63:0]       abits;
    } sum_t;

    // finished palettes of one block
    typedef struct packed {
        fmt_t                 fmt;
        logic [3:0][2:0][7:0] col;
        logic [3:0][7:0]      calpha;
        logic [7:0][7:0]      apal;
        logic [31:0]          idx;
        logic [63:0]          abits;
    } pal_t;

    function automatic logic [7:0] expand5(input logic [4:0] v);
        return {v, v[4:2]};
    endfunction

    function automatic logic [7:0] expand6(input logic [5:0] v);
        return {v, v[5:4]};
    endfunction

    // x / 3 for x < 768 by reciprocal multiply
    function automatic logic [7:0] div3(input logic [9:0] x);
        logic [19:0] p;
        p = {10'd0, x} * 20'd683;
        return p[18:11];
    endfunction

    // x / 7 for x < 1786
    function automatic logic [7:0] div7(input logic [10:0] x);
        logic [22:0] p;
        p = {12'd0, x} * 23'd2341;
        return p[21:14];
    endfunction

    // x / 5 for x < 1276
    function automatic logic [7:0] div5(input logic [10:0] x);
        logic [22:0] p;
        p = {12'd0, x} * 23'd3277;
        return p[21:14];
    endfunction

endpackage

// ===== hdl/bc1_bc2_bc3_block_decoder.sv =====
// Top level of the BC1/BC2/BC3 (DXT1/3/5) block decoder. One item on the blk channel is a
// compressed 4x4 block; it comes out as sixteen texel items in raster order, texel 15 carrying
// last_texel. A block leaves at one texel per cycle while texel_stall is low, set by the single
// texel output register; blocks follow each other with no gap, and a block's first texel goes
// through the stage 1, stage 2, walker and output registers. Stages: endpoint expansion and
// weighted sums, reciprocal-multiply divides for the palettes, texel walker with output register.
// depends on bcdec_pkg, bcdec_sum, bcdec_pal, bcdec_ser
module bc1_bc2_bc3_block_decoder (
    input  logic        clk,
    input  logic        rst_n,
    // configuration: block format, write only
    input  logic        cfg_write,
    input  logic [1:0]  cfg_data,
    // compressed block items
    input  logic        blk_valid,
    output logic        blk_stall,
    input  logic [15:0] color_end0,
    input  logic [15:0] color_end1,
    input  logic [31:0] color_indices,
    input  logic [63:0] alpha_bits,
    // decoded texel items
    output logic        texel_valid,
    input  logic        texel_stall,
    output logic [7:0]  red,
    output logic [7:0]  green,
    output logic [7:0]  blue,
    output logic [7:0]  alpha,
    output logic [3:0]  texel_pos,
    output logic        last_texel
);

    // format register, sampled with each block as it enters
    bcdec_pkg::fmt_t fmt_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            fmt_reg <= bcdec_pkg::FMT_DXT1_RGB;
        else if (cfg_write)
            fmt_reg <= bcdec_pkg::fmt_t'(cfg_data);
    end

    // stage 1 to stage 2
    logic            s1_valid, s1_stall;
    bcdec_pkg::sum_t s1_data;
    // stage 2 to texel walker
    logic            s2_valid, s2_stall;
    bcdec_pkg::pal_t s2_data;

    bcdec_sum u_sum (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (blk_valid),
        .in_stall      (blk_stall),
        .fmt           (fmt_reg),
        .color_end0    (color_end0),
        .color_end1    (color_end1),
        .color_indices (color_indices),
        .alpha_bits    (alpha_bits),
        .out_valid     (s1_valid),
        .out_stall     (s1_stall),
        .out_data      (s1_data)
    );

    bcdec_pal u_pal (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s1_valid),
        .in_stall  (s1_stall),
        .in_data   (s1_data),
        .out_valid (s2_valid),
        .out_stall (s2_stall),
        .out_data  (s2_data)
    );

    // holds one block and steps through its texels; a new block loads as the last texel leaves
    bcdec_ser u_ser (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (s2_valid),
        .in_stall   (s2_stall),
        .in_data    (s2_data),
        .out_valid  (texel_valid),
        .out_stall  (texel_stall),
        .red        (red),
        .green      (green),
        .blue       (blue),
        .alpha      (alpha),
        .texel_pos  (texel_pos),
        .last_texel (last_texel)
    );

endmodule

// ===== hdl/bcdec_sum.sv =====
// stage 1: endpoint expansion and palette weighted sums
// depends on bcdec_pkg
module bcdec_sum (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  bcdec_pkg::fmt_t    fmt,
    input  logic [15:0]        color_end0,
    input  logic [15:0]        color_end1,
    input  logic [31:0]        color_indices,
    input  logic [63:0]        alpha_bits,
    output logic               out_valid,
    input  logic               out_stall,
    output bcdec_pkg::sum_t    out_data
);

    logic            valid_reg;
    bcdec_pkg::sum_t data_reg;
    bcdec_pkg::sum_t data_next;

    assign in_stall  = valid_reg && out_stall;
    assign out_valid = valid_reg;
    assign out_data  = data_reg;

    always_comb
    begin
        logic [10:0] a0x;
        logic [10:0] a1x;
        a0x = {3'd0, alpha_bits[7:0]};
        a1x = {3'd0, alpha_bits[15:8]};
        data_next.fmt   = fmt;
        data_next.four  = (fmt == bcdec_pkg::FMT_DXT3) || (fmt == bcdec_pkg::FMT_DXT5)
                          || (color_end0 > color_end1);
        data_next.punch = (fmt == bcdec_pkg::FMT_DXT1_RGBA) && !(color_end0 > color_end1);
        data_next.c0[0] = bcdec_pkg::expand5(color_end0[15:11]);
        data_next.c0[1] = bcdec_pkg::expand6(color_end0[10:5]);
        data_next.c0[2] = bcdec_pkg::expand5(color_end0[4:0]);
        data_next.c1[0] = bcdec_pkg::expand5(color_end1[15:11]);
        data_next.c1[1] = bcdec_pkg::expand6(color_end1[10:5]);
        data_next.c1[2] = bcdec_pkg::expand5(color_end1[4:0]);
        for (int ch = 0; ch < 3; ch++)
        begin
            logic [9:0] sum01;
            sum01 = {2'd0, data_next.c0[ch]} + {2'd0, data_next.c1[ch]};
            data_next.mid[ch] = sum01[8:1];
            data_next.s2[ch]  = sum01 + {2'd0, data_next.c0[ch]};
            data_next.s3[ch]  = sum01 + {2'd0, data_next.c1[ch]};
        end
        data_next.a0   = alpha_bits[7:0];
        data_next.a1   = alpha_bits[15:8];
        data_next.a_gt = alpha_bits[7:0] > alpha_bits[15:8];
        for (int k = 1; k <= 6; k++)
        begin
            if (data_next.a_gt)
                data_next.asum[k-1] = 11'(7 - k) * a0x + 11'(k) * a1x;
            else if (k <= 4)
                data_next.asum[k-1] = 11'(5 - k) * a0x + 11'(k) * a1x;
            else
                data_next.asum[k-1] = 11'd0;
        end
        data_next.idx   = color_indices;
        data_next.abits = alpha_bits;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (!in_stall)
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
            data_reg <= data_next;
    end

endmodule

// ===== hdl/bcdec_pal.sv =====
// stage 2: constant divides that finish the colour and alpha palettes
// depends on bcdec_pkg
module bcdec_pal (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  bcdec_pkg::sum_t    in_data,
    output logic               out_valid,
    input  logic               out_stall,
    output bcdec_pkg::pal_t    out_data
);

    logic            valid_reg;
    bcdec_pkg::pal_t data_reg;
    bcdec_pkg::pal_t data_next;

    assign in_stall  = valid_reg && out_stall;
    assign out_valid = valid_reg;
    assign out_data  = data_reg;

    always_comb
    begin
        data_next.fmt = in_data.fmt;
        for (int ch = 0; ch < 3; ch++)
        begin
            data_next.col[0][ch] = in_data.c0[ch];
            data_next.col[1][ch] = in_data.c1[ch];
            data_next.col[2][ch] = in_data.four ? bcdec_pkg::div3(in_data.s2[ch])
                                                : in_data.mid[ch];
            data_next.col[3][ch] = in_data.four ? bcdec_pkg::div3(in_data.s3[ch]) : 8'd0;
        end
        data_next.calpha[0] = bcdec_pkg::ALPHA_OPAQUE;
        data_next.calpha[1] = bcdec_pkg::ALPHA_OPAQUE;
        data_next.calpha[2] = bcdec_pkg::ALPHA_OPAQUE;
        data_next.calpha[3] = in_data.punch ? bcdec_pkg::ALPHA_CLEAR : bcdec_pkg::ALPHA_OPAQUE;
        data_next.apal[0] = in_data.a0;
        data_next.apal[1] = in_data.a1;
        for (int k = 1; k <= 6; k++)
        begin
            if (in_data.a_gt)
                data_next.apal[k+1] = bcdec_pkg::div7(in_data.asum[k-1]);
            else if (k <= 4)
                data_next.apal[k+1] = bcdec_pkg::div5(in_data.asum[k-1]);
            else if (k == 5)
                data_next.apal[k+1] = bcdec_pkg::ALPHA_CLEAR;
            else
                data_next.apal[k+1] = bcdec_pkg::ALPHA_OPAQUE;
        end
        data_next.idx   = in_data.idx;
        data_next.abits = in_data.abits;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (!in_stall)
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
            data_reg <= data_next;
    end

endmodule

// ===== hdl/bcdec_ser.sv =====
// stage 3: walks the sixteen texels of a block into the output register
// depends on bcdec_pkg
module bcdec_ser (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  bcdec_pkg::pal_t    in_data,
    output logic               out_valid,
    input  logic               out_stall,
    output logic [7:0]         red,
    output logic [7:0]         green,
    output logic [7:0]         blue,
    output logic [7:0]         alpha,
    output logic [3:0]         texel_pos,
    output logic               last_texel
);

    logic            blk_valid_reg;
    bcdec_pkg::pal_t blk_reg;
    logic [3:0]      cnt_reg;
    logic            out_valid_reg;
    logic [7:0]      red_reg, green_reg, blue_reg, alpha_reg;
    logic [3:0]      pos_reg;
    logic            last_reg;

    logic            emit;
    logic            blk_done;
    logic [1:0]      ci;
    logic [3:0]      v3;
    logic [2:0]      ai;
    logic [5:0]      ai_lsb;
    logic [7:0]      alpha_next;

    assign emit     = blk_valid_reg && (!out_valid_reg || !out_stall);
    assign blk_done = emit && (cnt_reg == bcdec_pkg::TEXEL_LAST);
    assign in_stall = blk_valid_reg && !blk_done;

    assign ci     = blk_reg.idx[{cnt_reg, 1'b0} +: 2];
    assign v3     = blk_reg.abits[{cnt_reg, 2'b00} +: 4];
    assign ai_lsb = {2'd0, cnt_reg} * 6'd3 + bcdec_pkg::DXT5_IDX_LSB;
    assign ai     = blk_reg.abits[ai_lsb +: 3];

    always_comb
    begin
        unique case (blk_reg.fmt)
            bcdec_pkg::FMT_DXT3: alpha_next = {v3, v3};
            bcdec_pkg::FMT_DXT5: alpha_next = blk_reg.apal[ai];
            default:             alpha_next = blk_reg.calpha[ci];
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            blk_valid_reg <= 1'b0;
            cnt_reg       <= 4'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_valid && !in_stall)
            begin
                blk_valid_reg <= 1'b1;
                cnt_reg       <= 4'd0;
            end
            else if (blk_done)
                blk_valid_reg <= 1'b0;
            else if (emit)
                cnt_reg <= cnt_reg + 4'd1;

            if (emit)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
            blk_reg <= in_data;
        if (emit)
        begin
            red_reg   <= blk_reg.col[ci][0];
            green_reg <= blk_reg.col[ci][1];
            blue_reg  <= blk_reg.col[ci][2];
            alpha_reg <= alpha_next;
            pos_reg   <= cnt_reg;
            last_reg  <= (cnt_reg == bcdec_pkg::TEXEL_LAST);
        end
    end

    assign out_valid  = out_valid_reg;
    assign red        = red_reg;
    assign green      = green_reg;
    assign blue       = blue_reg;
    assign alpha      = alpha_reg;
    assign texel_pos  = pos_reg;
    assign last_texel = last_reg;

endmodule

// ===== hdl/bcdec_checker.sv =====
// port-level checker for the block decoder, bound to the top level
// depends on bc1_bc2_bc3_block_decoder_assert.svh
`include "bc1_bc2_bc3_block_decoder_assert.svh"

module bcdec_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       texel_valid,
    input logic       texel_stall,
    input logic [3:0] texel_pos,
    input logic       last_texel
);

    // last flag exactly on texel fifteen
    `BCDEC_ASSERT_NOW(a_last_pos, clk, rst_n, !texel_valid || (last_texel == (texel_pos == 4'd15)), "last_texel does not match texel 15")

    // texels of one block follow each other with no gap
    `BCDEC_ASSERT_NEXT(a_pos_step, clk, rst_n, texel_valid && !texel_stall && !last_texel, texel_valid && (texel_pos == $past(texel_pos) + 4'd1), "texel sequence broken")

    // a new block starts at texel zero
    `BCDEC_ASSERT_NEXT(a_pos_wrap, clk, rst_n, texel_valid && !texel_stall && last_texel, !texel_valid || (texel_pos == 4'd0), "block does not start at texel 0")

    // stalled texel is held
    `BCDEC_ASSERT_NEXT(a_hold, clk, rst_n, texel_valid && texel_stall, texel_valid && $stable(texel_pos), "stalled texel changed")

endmodule

bind bc1_bc2_bc3_block_decoder bcdec_checker u_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .texel_valid (texel_valid),
    .texel_stall (texel_stall),
    .texel_pos   (texel_pos),
    .last_texel  (last_texel)
);

// ===== verif/testbench.sv =====
// testbench for the bc1/bc2/bc3 block decoder: sends compressed 4x4 blocks in every format
// and checks the sixteen decoded texels of each block against a local prediction
// depends on bcdec_pkg and bc1_bc2_bc3_block_decoder
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import bcdec_pkg::*;

    localparam int HALF_PERIOD  = 6;
    // slowest correct run is 430 blocks of 16 texels under 36% stall, far below this
    localparam int CYCLE_LIMIT  = 400000;
    // cycles let pass once nothing is expected
    localparam int DRAIN_CYCLES = 24;
    // keep the log short when the block is badly broken
    localparam int MAX_PRINTED  = 60;
    localparam int HOLD_CYCLES  = 400;

    // one compressed block as it goes on the input channel
    typedef struct {
        logic [15:0] end0;
        logic [15:0] end1;
        logic [31:0] indices;
        logic [63:0] abits;
    } block_t;

    // one decoded texel as it should leave the block
    typedef struct {
        logic [7:0] r;
        logic [7:0] g;
        logic [7:0] b;
        logic [7:0] a;
        logic [3:0] pos;
        logic       last;
    } texel_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_write = 1'b0;
    logic [1:0]  cfg_data = FMT_DXT1_RGB;
    logic        blk_valid = 1'b0;
    logic        blk_stall;
    logic [15:0] color_end0 = '0;
    logic [15:0] color_end1 = '0;
    logic [31:0] color_indices = '0;
    logic [63:0] alpha_bits = '0;
    logic        texel_valid;
    logic        texel_stall = 1'b0;
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    logic [7:0]  alpha;
    logic [3:0]  texel_pos;
    logic        last_texel;

    // format the block holds right now, tracked alongside every write
    fmt_t   format_now = FMT_DXT1_RGB;
    // texels still owed by the block, oldest first
    texel_t expected_texels[$];
    int     mismatches = 0;
    int     cycle_count = 0;
    // idle odds in percent for the sender and the receiver
    int     gap_pct = 36;
    int     stall_pct = 36;
    // receiver hold-off, counted down by the stall process
    int     hold_left = 0;

    bc1_bc2_bc3_block_decoder DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_write     (cfg_write),
        .cfg_data      (cfg_data),
        .blk_valid     (blk_valid),
        .blk_stall     (blk_stall),
        .color_end0    (color_end0),
        .color_end1    (color_end1),
        .color_indices (color_indices),
        .alpha_bits    (alpha_bits),
        .texel_valid   (texel_valid),
        .texel_stall   (texel_stall),
        .red           (red),
        .green         (green),
        .blue          (blue),
        .alpha         (alpha),
        .texel_pos     (texel_pos),
        .last_texel    (last_texel)
    );

    always #(HALF_PERIOD) clk = ~clk;

    // run limit: a hung handshake ends here
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("testbench NOT OK");
            $finish;
        end
    end

    // widen an rgb565 channel to 8 bits by repeating its top bits
    function automatic int unsigned widen(int unsigned v, int bits);
        return (v << (8 - bits)) | (v >> (2 * bits - 8));
    endfunction

    // work out the sixteen texels of one block and queue them
    function automatic void predict_block(fmt_t fmt, block_t blk);
        int unsigned lo[3];
        int unsigned hi[3];
        int unsigned colour[4][3];
        int unsigned calpha[4];
        int unsigned apal[8];
        int unsigned a0;
        int unsigned a1;
        int unsigned ci;
        int unsigned v;
        int          ch;
        int          k;
        int          i;
        bit          four;
        texel_t      t;

        // dxt3 and dxt5 ignore endpoint order, dxt1 picks the mode from it
        four = (fmt == FMT_DXT3) || (fmt == FMT_DXT5) || (blk.end0 > blk.end1);
        lo[0] = widen(32'(blk.end0[15:11]), 5);
        lo[1] = widen(32'(blk.end0[10:5]), 6);
        lo[2] = widen(32'(blk.end0[4:0]), 5);
        hi[0] = widen(32'(blk.end1[15:11]), 5);
        hi[1] = widen(32'(blk.end1[10:5]), 6);
        hi[2] = widen(32'(blk.end1[4:0]), 5);
        for (ch = 0; ch < 3; ch++)
        begin
            colour[0][ch] = lo[ch];
            colour[1][ch] = hi[ch];
            if (four)
            begin
                colour[2][ch] = (2 * lo[ch] + hi[ch]) / 3;
                colour[3][ch] = (lo[ch] + 2 * hi[ch]) / 3;
            end
            else
            begin
                colour[2][ch] = (lo[ch] + hi[ch]) >> 1;
                colour[3][ch] = 0;
            end
        end
        for (k = 0; k < 4; k++)
            calpha[k] = 255;
        // punch-through: black entry is transparent only in three-colour mode
        if (fmt == FMT_DXT1_RGBA && !four)
            calpha[3] = 0;

        a0 = 32'(blk.abits[7:0]);
        a1 = 32'(blk.abits[15:8]);
        apal[0] = a0;
        apal[1] = a1;
        if (a0 > a1)
        begin
            for (k = 1; k <= 6; k++)
                apal[k + 1] = ((7 - k) * a0 + k * a1) / 7;
        end
        else
        begin
            for (k = 1; k <= 4; k++)
                apal[k + 1] = ((5 - k) * a0 + k * a1) / 5;
            apal[6] = 0;
            apal[7] = 255;
        end

        for (i = 0; i < 16; i++)
        begin
            ci = 32'(blk.indices[2 * i +: 2]);
            t.r = 8'(colour[ci][0]);
            t.g = 8'(colour[ci][1]);
            t.b = 8'(colour[ci][2]);
            case (fmt)
                FMT_DXT3:
                begin
                    v = 32'(blk.abits[4 * i +: 4]);
                    t.a = 8'((v << 4) | v);
                end
                FMT_DXT5:
                    t.a = 8'(apal[blk.abits[16 + 3 * i +: 3]]);
                default:
                    t.a = 8'(calpha[ci]);
            endcase
            t.pos = 4'(i);
            t.last = (i == 15);
            expected_texels.push_back(t);
        end
    endfunction

    task automatic report_mismatch(string what, longint unsigned got, longint unsigned want);
        if (mismatches < MAX_PRINTED)
            $display("[%0t] mismatch on %s: got %0h, expected %0h", $realtime, what, got, want);
        mismatches++;
    endtask

    // texel checker: every accepted texel against the oldest one owed
    always @(posedge clk)
    begin : check_texel
        texel_t want;
        if (rst_n && texel_valid && !texel_stall)
        begin
            if (expected_texels.size() == 0)
                report_mismatch("texel with nothing expected, pos", 64'(texel_pos), 64'd0);
            else
            begin
                want = expected_texels.pop_front();
                if (red !== want.r)
                    report_mismatch("red", 64'(red), 64'(want.r));
                if (green !== want.g)
                    report_mismatch("green", 64'(green), 64'(want.g));
                if (blue !== want.b)
                    report_mismatch("blue", 64'(blue), 64'(want.b));
                if (alpha !== want.a)
                    report_mismatch("alpha", 64'(alpha), 64'(want.a));
                if (texel_pos !== want.pos)
                    report_mismatch("texel_pos", 64'(texel_pos), 64'(want.pos));
                if (last_texel !== want.last)
                    report_mismatch("last_texel", 64'(last_texel), 64'(want.last));
            end
        end
    end

    // receiver stall: random, or solid while a hold-off is running
    always @(negedge clk)
    begin
        if (hold_left > 0)
        begin
            texel_stall <= 1'b1;
            hold_left = hold_left - 1;
        end
        else
            texel_stall <= ($urandom_range(99) < stall_pct);
    end

    // offer one block, starting and ending on a falling edge; valid stays high
    // afterwards so back-to-back blocks never drop it
    task automatic send_block(block_t blk);
        while ($urandom_range(99) < gap_pct)
        begin
            blk_valid <= 1'b0;
            @(negedge clk);
        end
        blk_valid <= 1'b1;
        color_end0 <= blk.end0;
        color_end1 <= blk.end1;
        color_indices <= blk.indices;
        alpha_bits <= blk.abits;
        do
            @(posedge clk);
        while (blk_stall);
        predict_block(format_now, blk);
        @(negedge clk);
    endtask

    // stop offering and wait until every owed texel has come, then a few cycles more
    task automatic drain_texels();
        blk_valid <= 1'b0;
        while (expected_texels.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    // format change, only with the block idle
    task automatic set_format(fmt_t fmt);
        drain_texels();
        cfg_write <= 1'b1;
        cfg_data <= fmt;
        @(negedge clk);
        cfg_write <= 1'b0;
        format_now = fmt;
    endtask

    function automatic block_t make_block(logic [15:0] e0, logic [15:0] e1,
                                          logic [31:0] idx, logic [63:0] ab);
        block_t blk;
        blk.end0 = e0;
        blk.end1 = e1;
        blk.indices = idx;
        blk.abits = ab;
        return blk;
    endfunction

    function automatic block_t random_block();
        block_t blk;
        blk.end0 = 16'($urandom);
        blk.end1 = 16'($urandom);
        // lean on the mode boundaries now and then
        case ($urandom_range(7))
            0: blk.end1 = blk.end0;
            1: blk.end0 = 16'hffff;
            2: blk.end1 = 16'hffff;
            3: blk.end1 = blk.end0 + 16'd1;
            default: ;
        endcase
        blk.indices = $urandom;
        blk.abits = {$urandom, $urandom};
        // equal alpha endpoints take the five-step palette
        if ($urandom_range(5) == 0)
            blk.abits[15:8] = blk.abits[7:0];
        return blk;
    endfunction

    // no write yet: the block must decode as dxt1 rgb
    task automatic test_reset_format();
        send_block(make_block(16'hf800, 16'h07e0, 32'he4e4e4e4, 64'h0));
        // three-colour block all on black entry, alpha stays opaque
        send_block(make_block(16'h001f, 16'h001f, 32'hffffffff, '1));
        drain_texels();
    endtask

    // extremes of the endpoints and alpha palettes in each format
    task automatic test_directed_formats();
        logic [47:0] ramp;
        int          f;
        int          i;

        // alpha index per texel runs 0..7 twice
        for (i = 0; i < 16; i++)
            ramp[3 * i +: 3] = 3'(i);
        for (f = 0; f < 4; f++)
        begin
            set_format(fmt_t'(f));
            // four-colour, a0 above a1
            send_block(make_block(16'hffff, 16'h0000, 32'he4e4e4e4, {ramp, 8'h00, 8'hff}));
            // three-colour for dxt1, a0 below a1
            send_block(make_block(16'h0000, 16'hffff, 32'h1b1b1b1b, {ramp, 8'hff, 8'h00}));
            // equal endpoints and equal alphas
            send_block(make_block(16'ha5a5, 16'ha5a5, 32'h9c9c6363, {~ramp, 8'h80, 8'h80}));
            // every dxt3 nibble value once
            send_block(make_block(16'h7bef, 16'h8410, 32'hd82d72b4, 64'hfedcba9876543210));
        end
    endtask

    task automatic test_random_blocks(fmt_t fmt, int count, int idle_pct);
        int n;
        set_format(fmt);
        gap_pct = idle_pct;
        stall_pct = idle_pct;
        for (n = 0; n < count; n++)
            send_block(random_block());
        gap_pct = 36;
        stall_pct = 36;
    endtask

    // receiver holds off while blocks keep coming, so the pipe fills and stalls its input
    task automatic test_backpressure();
        int n;
        set_format(FMT_DXT3);
        gap_pct = 0;
        hold_left = HOLD_CYCLES;
        for (n = 0; n < 12; n++)
            send_block(random_block());
        gap_pct = 36;
    endtask

    initial
    begin
        repeat (6) @(negedge clk);
        rst_n = 1'b1;

        test_reset_format();
        test_directed_formats();
        test_random_blocks(FMT_DXT5, 100, 36);
        test_random_blocks(FMT_DXT1_RGB, 100, 36);
        test_random_blocks(FMT_DXT3, 100, 36);
        // long stretch with no idling on either side
        test_random_blocks(FMT_DXT1_RGBA, 60, 0);
        test_random_blocks(FMT_DXT1_RGBA, 40, 36);
        test_backpressure();
        drain_texels();

        if (mismatches == 0)
            $display("testbench OK");
        else
            $display("testbench NOT OK");
        $finish;
    end

endmodule
